@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL; included by fdoc_useq.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FDOC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FDOC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FDOC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FDOC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hw/rtl/fdoc_pkg.sv @@
package fdoc_pkg;

    localparam int LENGTH_W = 13;

    typedef logic [3:0] upc_t;

    // microprogram addresses
    localparam upc_t UA_WAIT   = 4'd0;
    localparam upc_t UA_CHECK  = 4'd1;
    localparam upc_t UA_CLEAR  = 4'd2;
    localparam upc_t UA_MARK0  = 4'd3;
    localparam upc_t UA_STEP   = 4'd4;
    localparam upc_t UA_MARK   = 4'd5;
    localparam upc_t UA_FAIL   = 4'd6;
    localparam upc_t UA_FINISH = 4'd7;
    localparam upc_t UA_OUT    = 4'd8;
    localparam upc_t UA_RET    = 4'd9;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_MARK0,
        OP_STEP,
        OP_MARK,
        OP_FINISH,
        OP_FAIL
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_TOO_BIG,
        COND_CLR_LAST,
        COND_WALK_DONE,
        COND_HIT,
        COND_OUT_READY
    } cond_t;

    // one control word; jump to target when (cond ^ cond_inv), else fall through
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  cond_inv;
        upc_t  target;
        logic  in_ready;
        logic  out_valid;
    } ctrl_t;

    typedef struct packed {
        logic too_big;
        logic clr_last;
        logic walk_done;
        logic hit;
    } status_t;

    function automatic ctrl_t mk_word(op_t op, cond_t cond, logic inv, upc_t tgt,
                                      logic rdy, logic ov);
        ctrl_t w;
        w.op        = op;
        w.cond      = cond;
        w.cond_inv  = inv;
        w.target    = tgt;
        w.in_ready  = rdy;
        w.out_valid = ov;
        return w;
    endfunction

    function automatic ctrl_t ucode_rom(upc_t addr);
        ctrl_t w;
        case (addr)
            UA_WAIT:   w = mk_word(OP_LOAD,   COND_IN_VALID,  1'b1, UA_WAIT,   1'b1, 1'b0);
            UA_CHECK:  w = mk_word(OP_NOP,    COND_TOO_BIG,   1'b0, UA_FAIL,   1'b0, 1'b0);
            UA_CLEAR:  w = mk_word(OP_CLEAR,  COND_CLR_LAST,  1'b1, UA_CLEAR,  1'b0, 1'b0);
            UA_MARK0:  w = mk_word(OP_MARK0,  COND_ALWAYS,    1'b1, UA_WAIT,   1'b0, 1'b0);
            UA_STEP:   w = mk_word(OP_STEP,   COND_WALK_DONE, 1'b0, UA_FINISH, 1'b0, 1'b0);
            UA_MARK:   w = mk_word(OP_MARK,   COND_HIT,       1'b1, UA_STEP,   1'b0, 1'b0);
            UA_FAIL:   w = mk_word(OP_FAIL,   COND_ALWAYS,    1'b0, UA_OUT,    1'b0, 1'b0);
            UA_FINISH: w = mk_word(OP_FINISH, COND_ALWAYS,    1'b0, UA_OUT,    1'b0, 1'b0);
            UA_OUT:    w = mk_word(OP_NOP,    COND_OUT_READY, 1'b1, UA_OUT,    1'b0, 1'b1);
            UA_RET:    w = mk_word(OP_NOP,    COND_ALWAYS,    1'b0, UA_WAIT,   1'b0, 1'b0);
            default:   w = mk_word(OP_NOP,    COND_ALWAYS,    1'b0, UA_WAIT,   1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/fdoc_req_if.sv @@
interface fdoc_req_if
    import fdoc_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [LENGTH_W-1:0] length;

    modport source (output valid, output length, input ready);
    modport sink   (input valid, input length, output ready);
endinterface

@@ hw/rtl/fdoc_rsp_if.sv @@
interface fdoc_rsp_if;
    logic valid;
    logic ready;
    logic maximal;

    modport source (output valid, output maximal, input ready);
    modport sink   (input valid, input maximal, output ready);
endinterface

@@ hw/rtl/folded_doubling_orbit_check_core.sv @@
// Folded doubling orbit checker.
// req channel carries one length n per item; rsp returns one maximal bit per item.
// The orbit 0 -> 2i+1 (folded to 2n-(2i+1) past n-1) is walked for at most n/2
// steps against a visited bitmap; maximal = 1 when no position repeats and all
// odd positions below n are reached. A length above MAX_LENGTH answers 0.
// One item is in flight at a time: req.ready is high only while the sequencer
// waits for work, so the next item is taken after the result is delivered.
// For an accepted length the bitmap is first cleared over its n+2 slots, one
// entry per cycle on the single write port, then each orbit step is a
// registered bitmap read followed by a mark. An early repeat ends the walk at
// once; an oversized length goes from the range check straight to a 0 result.
// Reset returns the sequencer to its wait step; the bitmap needs no reset since
// each item clears the slots it can touch. While rsp.ready is low the result
// holds on rsp and no new item is taken.
module folded_doubling_orbit_check_core
    import fdoc_pkg::*;
#(
    parameter int MAX_LENGTH = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    fdoc_req_if.sink  req,
    fdoc_rsp_if.source rsp
);
    ctrl_t   ctrl;
    status_t status;
    logic    maximal;

    fdoc_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    fdoc_dpath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .length  (req.length),
        .status  (status),
        .maximal (maximal)
    );

    assign req.ready   = ctrl.in_ready;
    assign rsp.valid   = ctrl.out_valid;
    assign rsp.maximal = maximal;
endmodule

@@ hw/rtl/fdoc_bitmap.sv @@
module fdoc_bitmap #(
    parameter int DEPTH = 4098,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);
    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/fdoc_dpath.sv @@
module fdoc_dpath
    import fdoc_pkg::*;
#(
    parameter int MAX_LENGTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_t               ctrl,
    input  logic [LENGTH_W-1:0] length,
    output status_t             status,
    output logic                maximal
);
    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam int PW = LW + 1;
    localparam int DW = LW + 2;
    localparam int SW = $clog2(MAX_LENGTH + 2);
    localparam int CW = $clog2(MAX_LENGTH / 2 + 1);

    logic [LW-1:0]        n_reg;
    logic                 too_big_reg;
    logic [SW-1:0]        clr_reg;
    logic signed [PW-1:0] pos_reg;
    logic [CW-1:0]        half_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        hits_reg;
    logic                 res_reg;

    logic [LW-1:0]        n_in;
    logic                 too_big_in;
    logic signed [DW-1:0] dbl;
    logic signed [DW-1:0] n_s;
    logic signed [DW-1:0] two_n;
    logic signed [DW-1:0] nxt;
    logic signed [DW-1:0] nxt_p1;
    logic signed [PW-1:0] pos_p1;
    logic [SW-1:0]        rd_slot;
    logic [SW-1:0]        mark_slot;
    logic [SW-1:0]        last_slot;
    logic                 odd_hit;
    logic                 hit;

    logic                 bm_we;
    logic [SW-1:0]        bm_waddr;
    logic                 bm_wdata;

    assign n_in       = LW'(length);
    assign too_big_in = ({{(32 - LENGTH_W){1'b0}}, length} > 32'(MAX_LENGTH));

    // folded doubling: 2i+1, folded back to 2n-(2i+1) past the end
    assign dbl    = $signed({pos_reg, 1'b1});
    assign n_s    = $signed({2'b00, n_reg});
    assign two_n  = $signed({1'b0, n_reg, 1'b0});
    assign nxt    = (dbl >= n_s) ? (two_n - dbl) : dbl;
    assign nxt_p1 = nxt + $signed(DW'(1));
    assign pos_p1 = pos_reg + $signed(PW'(1));

    // bitmap slots hold positions -1..n at offset one
    assign rd_slot   = nxt_p1[SW-1:0];
    assign mark_slot = pos_p1[SW-1:0];
    assign last_slot = SW'(n_reg) + SW'(1);

    assign odd_hit = (pos_reg > $signed(PW'(0))) && (pos_reg < $signed({1'b0, n_reg}))
                     && pos_reg[0];

    always_comb
    begin
        bm_we    = 1'b0;
        bm_waddr = clr_reg;
        bm_wdata = 1'b0;
        case (ctrl.op)
            OP_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_reg;
                bm_wdata = 1'b0;
            end
            OP_MARK0:
            begin
                bm_we    = 1'b1;
                bm_waddr = SW'(1);
                bm_wdata = 1'b1;
            end
            OP_MARK:
            begin
                bm_we    = 1'b1;
                bm_waddr = mark_slot;
                bm_wdata = 1'b1;
            end
            default:
            begin
                bm_we = 1'b0;
            end
        endcase
    end

    fdoc_bitmap #(
        .DEPTH (MAX_LENGTH + 2),
        .AW    (SW)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (rd_slot),
        .rdata (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= '0;
            too_big_reg <= 1'b0;
            clr_reg     <= '0;
            pos_reg     <= '0;
            half_reg    <= '0;
            cnt_reg     <= '0;
            hits_reg    <= '0;
            res_reg     <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    n_reg       <= n_in;
                    too_big_reg <= too_big_in;
                    half_reg    <= CW'(n_in >> 1);
                    clr_reg     <= '0;
                    pos_reg     <= '0;
                    cnt_reg     <= '0;
                    hits_reg    <= '0;
                end
                OP_CLEAR:
                begin
                    clr_reg <= clr_reg + SW'(1);
                end
                OP_STEP:
                begin
                    pos_reg <= nxt[PW-1:0];
                end
                OP_MARK:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (odd_hit)
                    begin
                        hits_reg <= hits_reg + CW'(1);
                    end
                end
                OP_FINISH:
                begin
                    res_reg <= (hits_reg == half_reg);
                end
                OP_FAIL:
                begin
                    res_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.too_big   = too_big_reg;
    assign status.clr_last  = (clr_reg == last_slot);
    assign status.walk_done = (cnt_reg == half_reg);
    assign status.hit       = hit;
    assign maximal          = res_reg;
endmodule

@@ hw/rtl/fdoc_useq.sv @@
`include "assert_macros.svh"

module fdoc_useq
    import fdoc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    out_ready,
    input  status_t status,
    output ctrl_t   ctrl
);
    upc_t  upc_reg;
    upc_t  upc_next;
    ctrl_t word;
    logic  cond_val;
    logic  take;

    assign word = ucode_rom(upc_reg);

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:    cond_val = 1'b1;
            COND_IN_VALID:  cond_val = in_valid;
            COND_TOO_BIG:   cond_val = status.too_big;
            COND_CLR_LAST:  cond_val = status.clr_last;
            COND_WALK_DONE: cond_val = status.walk_done;
            COND_HIT:       cond_val = status.hit;
            COND_OUT_READY: cond_val = out_ready;
            default:        cond_val = 1'b0;
        endcase
    end

    assign take     = cond_val ^ word.cond_inv;
    assign upc_next = take ? word.target : upc_reg + upc_t'(1);

    // the load only fires on an accepted item
    always_comb
    begin
        ctrl = word;
        if (word.op == OP_LOAD && !in_valid)
        begin
            ctrl.op = OP_NOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    `FDOC_ASSERT_IMP(a_no_overlap, clk, rst_n, word.out_valid, !word.in_ready,
                     "input taken while a result is pending")
    `FDOC_ASSERT_NXT(a_accept_check, clk, rst_n, word.in_ready && in_valid,
                     upc_reg == UA_CHECK, "accepted item did not reach range check")
    `FDOC_ASSERT_IMP(a_mark_after_step, clk, rst_n, upc_reg == UA_MARK,
                     $past(upc_reg) == UA_STEP, "mark without a preceding bitmap read")
    `FDOC_ASSERT_NXT(a_out_hold, clk, rst_n, word.out_valid && !out_ready,
                     upc_reg == UA_OUT, "result dropped while stalled")
endmodule

@@ tb/folded_doubling_orbit_check_core_tb.sv @@
`timescale 1ns / 1ps

module folded_doubling_orbit_check_core_tb;
    import fdoc_pkg::*;

    localparam int MAX_LEN = 4096;
    localparam int LEN_MAX_CODE = (1 << LENGTH_W) - 1;
    localparam int MAX_REPORTS = 10;

    class maximal_tracker;
        bit expected_maximal[$];
        int mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // walks the folded doubling orbit from 0; the map is offset by one so -1 fits
        static function bit orbit_is_maximal(logic [LENGTH_W-1:0] n);
            bit visited [0:MAX_LEN+1];
            int ni;
            int pos;
            int nxt;
            int half;
            int odd_hits;
            ni = int'(n);
            if (ni > MAX_LEN)
                return 1'b0;
            half = ni / 2;
            pos = 0;
            odd_hits = 0;
            foreach (visited[k])
                visited[k] = 1'b0;
            visited[1] = 1'b1;
            for (int s = 0; s < half; s++)
            begin
                nxt = 2 * pos + 1;
                if (nxt > ni - 1)
                    nxt = 2 * ni - nxt;
                pos = nxt;
                if (pos + 1 >= MAX_LEN + 2)
                    return 1'b0;
                if (visited[pos + 1])
                    return 1'b0;
                visited[pos + 1] = 1'b1;
                if (pos > 0 && pos < ni && (pos % 2) == 1)
                    odd_hits++;
            end
            return odd_hits == half;
        endfunction

        function void note_length(logic [LENGTH_W-1:0] n);
            expected_maximal = {expected_maximal, orbit_is_maximal(n)};
        endfunction

        function void check_maximal(logic got);
            bit want;
            if (expected_maximal.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result %b with nothing outstanding", $time, got);
                return;
            end
            want = expected_maximal.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: maximal mismatch, expected %b got %b", $time, want, got);
            end
        endfunction

        function int pending();
            return expected_maximal.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    maximal_tracker tracker;

    fdoc_req_if req_ch ();
    fdoc_rsp_if rsp_ch ();

    folded_doubling_orbit_check_core #(
        .MAX_LENGTH(MAX_LEN)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // reads at the edge see pre-edge values, i.e. what the edge sampled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                tracker.note_length(req_ch.length);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_maximal(rsp_ch.maximal);
        end
    end

    always @(posedge clk)
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    task automatic push_length(input logic [LENGTH_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.length <= n;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // one edge first so the monitor has noted the last accepted item
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // mostly short lengths, some steered toward maximal ones; few near the top, some beyond MAX_LEN
    function automatic logic [LENGTH_W-1:0] pick_length();
        int sel;
        int n;
        sel = $urandom_range(99);
        if (sel < 35)
            n = $urandom_range(200, 1);
        else if (sel < 70)
        begin
            n = $urandom_range(200, 1);
            for (int t = 0; t < 60 && !maximal_tracker::orbit_is_maximal(n[LENGTH_W-1:0]); t++)
                n = $urandom_range(300, 1);
        end
        else if (sel < 80)
            n = $urandom_range(1000, 201);
        else if (sel < 84)
            n = $urandom_range(MAX_LEN, 1001);
        else if (sel < 95)
            n = $urandom_range(LEN_MAX_CODE, MAX_LEN + 1);
        else
            n = $urandom_range(3, 0);
        return n[LENGTH_W-1:0];
    endfunction

    initial
    begin
        int directed [$];
        tracker = new();
        send_idle_pct = 11;
        recv_idle_pct = 57;
        rst_n <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.length <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero and one, tiny lengths, odd lengths whose fold lands on n and then -1,
        // the top of the bitmap and lengths beyond it
        directed = {0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 15, 16, 31, 33, 64, 100,
                    2048, 4094, 4095, 4096, 4097, 6000, LEN_MAX_CODE};
        foreach (directed[k])
            push_length(directed[k][LENGTH_W-1:0]);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < 39; i++)
                push_length(pick_length());
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/fdoc_pkg.sv
hw/rtl/fdoc_req_if.sv
hw/rtl/fdoc_rsp_if.sv
hw/rtl/fdoc_bitmap.sv
hw/rtl/fdoc_dpath.sv
hw/rtl/fdoc_useq.sv
hw/rtl/folded_doubling_orbit_check_core.sv
tb/folded_doubling_orbit_check_core_tb.sv
